[rtl/esc_pkg.sv]
package esc_pkg;

  localparam int DATA_W = 64;
  localparam int ADDR_W = 6;
  localparam int DIV_W  = 64;
  localparam int TEMP_W = 32;
  localparam int HUM_W  = 17;

  typedef enum logic [2:0] {
    REG_CAL_TEMP    = 3'd0,
    REG_CAL_PRESS_A = 3'd1,
    REG_CAL_PRESS_B = 3'd2,
    REG_CAL_MIXED   = 3'd3,
    REG_CAL_HUM_B   = 3'd4
  } reg_idx_t;

  // low 64 bits of x * c, c a signed 17-bit value, as two 32-bit partial products
  function automatic logic [63:0] mul64x17(input logic [63:0] x, input logic signed [16:0] c);
    logic signed [49:0] lo;
    logic [31:0] cs;
    logic [31:0] hi;
    lo = $signed({1'b0, x[31:0]}) * c;
    cs = 32'(c);
    hi = x[63:32] * cs;
    return 64'(lo) + {hi, 32'b0};
  endfunction

endpackage

[rtl/env_sensor_compensation.sv]
// Sensor compensation pipeline. Takes one raw temperature/pressure/humidity beat per cycle
// and returns its compensated beat through 9 stages ahead of the pressure divide,
// a 66-stage signed 64-bit divider (one quotient bit a stage) and 4 stages after it. A stall
// on the output holds the whole pipeline. The user must write calibration words over the APB
// port (8-byte stride) only while no beat is in flight; the block does not enforce this.
module env_sensor_compensation (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [esc_pkg::ADDR_W-1:0] paddr,
  input  logic [esc_pkg::DATA_W-1:0] pwdata,
  output logic [esc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [19:0]                raw_temp,
  input  logic [19:0]                raw_press,
  input  logic [15:0]                raw_hum,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [31:0]         temp_centideg,
  output logic [31:0]                press_q24_8,
  output logic [16:0]                hum_q22_10,
  output logic                       press_div_zero
);
  import esc_pkg::*;

  localparam int SIDE_W = TEMP_W + HUM_W;

  logic [47:0] cal_temp;
  logic [63:0] cal_press_a;
  logic [63:0] cal_press_b;
  logic [47:0] cal_mixed;
  logic [31:0] cal_hum_b;

  reg_idx_t ridx;
  logic     en;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_temp    <= '0;
      cal_press_a <= '0;
      cal_press_b <= '0;
      cal_mixed   <= '0;
      cal_hum_b   <= '0;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_CAL_TEMP:    cal_temp    <= pwdata[47:0];
        REG_CAL_PRESS_A: cal_press_a <= pwdata;
        REG_CAL_PRESS_B: cal_press_b <= pwdata;
        REG_CAL_MIXED:   cal_mixed   <= pwdata[47:0];
        REG_CAL_HUM_B:   cal_hum_b   <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_CAL_TEMP:    prdata = {16'b0, cal_temp};
      REG_CAL_PRESS_A: prdata = cal_press_a;
      REG_CAL_PRESS_B: prdata = cal_press_b;
      REG_CAL_MIXED:   prdata = {16'b0, cal_mixed};
      REG_CAL_HUM_B:   prdata = {32'b0, cal_hum_b};
      default:         prdata = '0;
    endcase
  end

  // calibration fields
  logic [15:0]        t1, p1;
  logic signed [31:0] t2, t3, h1, h2, h3, h4, h5, h6;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

  always_comb begin
    t1 = cal_temp[15:0];
    t2 = 32'($signed(cal_temp[31:16]));
    t3 = 32'($signed(cal_temp[47:32]));
    p1 = cal_press_a[15:0];
    p2 = $signed(cal_press_a[31:16]);
    p3 = $signed(cal_press_a[47:32]);
    p4 = $signed(cal_press_a[63:48]);
    p5 = $signed(cal_press_b[15:0]);
    p6 = $signed(cal_press_b[31:16]);
    p7 = $signed(cal_press_b[47:32]);
    p8 = $signed(cal_press_b[63:48]);
    p9 = $signed(cal_mixed[15:0]);
    h1 = $signed({24'b0, cal_mixed[23:16]});
    h2 = 32'($signed(cal_mixed[39:24]));
    h3 = $signed({24'b0, cal_mixed[47:40]});
    h4 = 32'($signed(cal_hum_b[11:0]));
    h5 = 32'($signed(cal_hum_b[23:12]));
    h6 = 32'($signed(cal_hum_b[31:24]));
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // pipeline registers
  logic               v0, v1, v2, v3, v4, v5, v6, v7, v8;
  logic [19:0]        r0_t, r0_p;
  logic [15:0]        r0_h;
  logic signed [31:0] s1_v1, s1_dd;
  logic [19:0]        s1_p, s2_p, s3_p, s4_p;
  logic [15:0]        s1_h, s2_h;
  logic signed [31:0] s2_tf;
  logic signed [31:0] s3_temp, s4_temp, s5_temp, s6_temp, s7_temp, s8_temp;
  logic [63:0]        s3_qsq;
  logic signed [49:0] s3_qp5, s3_qp2;
  logic signed [31:0] s3_ha, s3_xh6, s3_xh3;
  logic [63:0]        s4_q2, s4_q1b;
  logic signed [31:0] s4_ha, s4_hb0;
  logic [63:0]        s5_denp, s5_num;
  logic signed [31:0] s5_ha, s5_hb;
  logic [63:0]        s6_den, s6_num, s7_den, s7_num, s8_den, s8_num;
  logic signed [31:0] s6_hx2, s7_hx2, s7_ss;
  logic [16:0]        s8_hum;

  // stage combinational terms
  logic [31:0]        c1_a, c1_d;
  logic signed [31:0] c1_m, c2_m, c3_t5, c3_hx, c3_m6, c3_m3, c3_h5x, c3_hin;
  logic signed [33:0] c3_q1;
  logic signed [67:0] c3_qsq;
  logic signed [31:0] c4_m, c5_m, c8_tt, c8_x;
  logic [63:0]        c4_q2, c4_q3, c5_base;
  logic [20:0]        c5_pd;
  logic signed [31:0] c7_hs;

  always_comb begin
    c1_a   = {15'b0, r0_t[19:3]} - {15'b0, t1, 1'b0};
    c1_d   = {16'b0, r0_t[19:4]} - {16'b0, t1};
    c1_m   = $signed(c1_a) * t2;
    c2_m   = (s1_dd >>> 12) * t3;
    c3_t5  = s2_tf * 32'sd5 + 32'sd128;
    c3_q1  = 34'(s2_tf) - 34'sd128000;
    c3_qsq = c3_q1 * c3_q1;
    c3_hx  = s2_tf - 32'sd76800;
    c3_m6  = c3_hx * h6;
    c3_m3  = c3_hx * h3;
    c3_h5x = h5 * c3_hx;
    c3_hin = $signed({2'b0, s2_h, 14'b0}) - (h4 <<< 20) - c3_h5x + 32'sd16384;
    c4_q2  = mul64x17(s3_qsq, 17'(p6)) + (64'(s3_qp5) << 17) + (64'(p4) << 35);
    c4_q3  = mul64x17(s3_qsq, 17'(p3));
    c4_m   = s3_xh6 * s3_xh3;
    c5_pd  = 21'd1048576 - {1'b0, s4_p};
    c5_base = ({43'b0, c5_pd} << 31) - s4_q2;
    c5_m   = s4_hb0 * h2 + 32'sd8192;
    c7_hs  = s6_hx2 >>> 15;
    c8_tt  = (s7_ss >>> 7) * h1;
    c8_x   = s7_hx2 - (c8_tt >>> 4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v0, v1, v2, v3, v4, v5, v6, v7, v8} <= '0;
    end else if (en) begin
      {v0, v1, v2, v3, v4, v5, v6, v7, v8} <= {in_valid, v0, v1, v2, v3, v4, v5, v6, v7};
    end
    if (en) begin
      r0_t <= raw_temp;
      r0_p <= raw_press;
      r0_h <= raw_hum;

      s1_v1 <= c1_m >>> 11;
      s1_dd <= $signed(c1_d * c1_d);
      s1_p  <= r0_p;
      s1_h  <= r0_h;

      s2_tf <= s1_v1 + (c2_m >>> 14);
      s2_p  <= s1_p;
      s2_h  <= s1_h;

      s3_temp <= c3_t5 >>> 8;
      s3_qsq  <= c3_qsq[63:0];
      s3_qp5  <= c3_q1 * p5;
      s3_qp2  <= c3_q1 * p2;
      s3_ha   <= c3_hin >>> 15;
      s3_xh6  <= c3_m6 >>> 10;
      s3_xh3  <= (c3_m3 >>> 11) + 32'sd32768;
      s3_p    <= s2_p;

      s4_temp <= s3_temp;
      s4_q2   <= c4_q2;
      s4_q1b  <= 64'($signed(c4_q3) >>> 8) + (64'(s3_qp2) << 12);
      s4_ha   <= s3_ha;
      s4_hb0  <= (c4_m >>> 10) + 32'sd2097152;
      s4_p    <= s3_p;

      s5_temp <= s4_temp;
      s5_denp <= mul64x17(64'h0000_8000_0000_0000 + s4_q1b, {1'b0, p1});
      s5_num  <= c5_base * 64'd3125;
      s5_ha   <= s4_ha;
      s5_hb   <= c5_m >>> 14;

      s6_temp <= s5_temp;
      s6_den  <= 64'($signed(s5_denp) >>> 33);
      s6_num  <= s5_num;
      s6_hx2  <= s5_ha * s5_hb;

      s7_temp <= s6_temp;
      s7_den  <= s6_den;
      s7_num  <= s6_num;
      s7_hx2  <= s6_hx2;
      s7_ss   <= c7_hs * c7_hs;

      s8_temp <= s7_temp;
      s8_den  <= s7_den;
      s8_num  <= s7_num;
      if (c8_x < 0) begin
        s8_hum <= '0;
      end else if (c8_x > 32'sd419430400) begin
        s8_hum <= 17'd102400;
      end else begin
        s8_hum <= c8_x[28:12];
      end
    end
  end

  // pressure divide
  logic              dv_valid, dv_dz;
  logic [63:0]       dv_q;
  logic [SIDE_W-1:0] dv_side;

  esc_div #(
    .SIDE_W(SIDE_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v8),
    .num      (s8_num),
    .den      (s8_den),
    .side_in  ({s8_temp, s8_hum}),
    .out_valid(dv_valid),
    .quot     (dv_q),
    .dz       (dv_dz),
    .side_out (dv_side)
  );

  // after the divide
  logic               q1v, q2v, q3v;
  logic [SIDE_W-1:0]  q1_side, q2_side, q3_side;
  logic               q1_dz, q2_dz, q3_dz;
  logic [63:0]        q1_p, q1_s, q1_m1, q1_w2, q2_p, q2_w2, q2_ll;
  logic [31:0]        q2_cr;
  logic [63:0]        q3_sum;
  logic [63:0]        c9_s, c11_w1, c12_pr;

  always_comb begin
    c9_s   = 64'($signed(dv_q) >>> 13);
    c11_w1 = 64'($signed(q2_ll + {q2_cr, 32'b0}) >>> 25);
    c12_pr = 64'($signed(q3_sum) >>> 8) + (64'(p7) << 4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {q1v, q2v, q3v, out_valid} <= '0;
    end else if (en) begin
      {q1v, q2v, q3v, out_valid} <= {dv_valid, q1v, q2v, q3v};
    end
    if (en) begin
      q1_p    <= dv_q;
      q1_s    <= c9_s;
      q1_m1   <= mul64x17(c9_s, 17'(p9));
      q1_w2   <= 64'($signed(mul64x17(dv_q, 17'(p8))) >>> 19);
      q1_dz   <= dv_dz;
      q1_side <= dv_side;

      q2_p    <= q1_p;
      q2_w2   <= q1_w2;
      q2_ll   <= q1_m1[31:0] * q1_s[31:0];
      q2_cr   <= 32'(q1_m1[31:0] * q1_s[63:32]) + 32'(q1_m1[63:32] * q1_s[31:0]);
      q2_dz   <= q1_dz;
      q2_side <= q1_side;

      q3_sum  <= q2_p + c11_w1 + q2_w2;
      q3_dz   <= q2_dz;
      q3_side <= q2_side;

      press_q24_8    <= q3_dz ? 32'd0 : c12_pr[31:0];
      press_div_zero <= q3_dz;
      temp_centideg  <= $signed(q3_side[SIDE_W-1:HUM_W]);
      hum_q22_10     <= q3_side[HUM_W-1:0];
    end
  end

endmodule

[rtl/esc_div.sv]
module esc_div #(
  parameter int SIDE_W = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [esc_pkg::DIV_W-1:0] num,
  input  logic [esc_pkg::DIV_W-1:0] den,
  input  logic [SIDE_W-1:0]         side_in,
  output logic                      out_valid,
  output logic [esc_pkg::DIV_W-1:0] quot,
  output logic                      dz,
  output logic [SIDE_W-1:0]         side_out
);
  import esc_pkg::*;

  localparam int W = DIV_W;

  logic [W-1:0]      rem  [W+1];
  logic [W-1:0]      nq   [W+1];
  logic [W-1:0]      dv   [W+1];
  logic              neg  [W+1];
  logic              zd   [W+1];
  logic [SIDE_W-1:0] side [W+1];
  logic              vld  [W+1];

  // sign and magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      rem[0]  <= '0;
      nq[0]   <= num[W-1] ? (W'(0) - num) : num;
      dv[0]   <= den[W-1] ? (W'(0) - den) : den;
      neg[0]  <= num[W-1] ^ den[W-1];
      zd[0]   <= (den == '0);
      side[0] <= side_in;
    end
  end

  // one quotient bit a stage
  for (genvar i = 0; i < W; i++) begin : g_step
    logic [W:0] rsh;
    logic       ge;
    always_comb begin
      rsh = {rem[i], nq[i][W-1]};
      ge  = (rsh >= {1'b0, dv[i]});
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        rem[i+1]  <= ge ? W'(rsh - {1'b0, dv[i]}) : W'(rsh);
        nq[i+1]   <= {nq[i][W-2:0], ge};
        dv[i+1]   <= dv[i];
        neg[i+1]  <= neg[i];
        zd[i+1]   <= zd[i];
        side[i+1] <= side[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[W];
    end
    if (en) begin
      quot     <= neg[W] ? (W'(0) - nq[W]) : nq[W];
      dz       <= zd[W];
      side_out <= side[W];
    end
  end

endmodule

[sim/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import esc_pkg::*;

  localparam int LATENCY = 79;
  localparam longint LIMIT = 400000;

  typedef struct packed {
    logic [19:0] t;
    logic [19:0] p;
    logic [15:0] h;
  } sample_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] press;
    logic [16:0] hum;
    logic        dz;
  } comp_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 0, in_ready;
  logic [19:0] raw_temp = '0, raw_press = '0;
  logic [15:0] raw_hum = '0;
  logic out_valid, out_ready = 0;
  logic signed [31:0] temp_centideg;
  logic [31:0] press_q24_8;
  logic [16:0] hum_q22_10;
  logic press_div_zero;
  logic in_fire = 0;

  env_sensor_compensation dut (.*);

  always #2 clk = ~clk;

  logic [63:0] cal [5];
  sample_t pending_q[$];
  comp_t   expected_q[$];
  int errors = 0;
  longint cycle = 0;
  bit calm = 0;
  int hold = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t bad %s: got %h want %h", $time, what, got, want);
    errors++;
  endtask

  function automatic logic [31:0] asr32(input logic [31:0] x, input int s);
    return 32'($signed(x) >>> s);
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int s);
    return 64'($signed(x) >>> s);
  endfunction

  function automatic comp_t compensate(input sample_t s);
    logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6, a, v1, d, v2, tf, x, ha, hb, sq;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, q1, q2, p, ua, ub, qq, sh, w1, w2;
    logic na, nb;
    comp_t r;
    t1 = {16'b0, cal[0][15:0]};
    t2 = 32'($signed(cal[0][31:16]));
    t3 = 32'($signed(cal[0][47:32]));
    p1 = {48'b0, cal[1][15:0]};
    p2 = 64'($signed(cal[1][31:16]));
    p3 = 64'($signed(cal[1][47:32]));
    p4 = 64'($signed(cal[1][63:48]));
    p5 = 64'($signed(cal[2][15:0]));
    p6 = 64'($signed(cal[2][31:16]));
    p7 = 64'($signed(cal[2][47:32]));
    p8 = 64'($signed(cal[2][63:48]));
    p9 = 64'($signed(cal[3][15:0]));
    h1 = {24'b0, cal[3][23:16]};
    h2 = 32'($signed(cal[3][39:24]));
    h3 = {24'b0, cal[3][47:40]};
    h4 = 32'($signed(cal[4][11:0]));
    h5 = 32'($signed(cal[4][23:12]));
    h6 = 32'($signed(cal[4][31:24]));

    a  = {12'b0, 3'b0, s.t[19:3]} - (t1 << 1);
    v1 = asr32(a * t2, 11);
    d  = {16'b0, s.t[19:4]} - t1;
    v2 = asr32(asr32(d * d, 12) * t3, 14);
    tf = v1 + v2;
    r.temp = asr32(tf * 32'd5 + 32'd128, 8);

    q1 = 64'($signed(tf)) - 64'd128000;
    q2 = q1 * q1 * p6;
    q2 = q2 + ((q1 * p5) << 17);
    q2 = q2 + (p4 << 35);
    q1 = asr64(q1 * q1 * p3, 8) + ((q1 * p2) << 12);
    q1 = asr64(((64'd1 << 47) + q1) * p1, 33);
    r.press = '0;
    r.dz = (q1 == 0);
    if (!r.dz) begin
      p = 64'd1048576 - {44'b0, s.p};
      p = ((p << 31) - q2) * 64'd3125;
      na = p[63];
      nb = q1[63];
      ua = na ? -p : p;
      ub = nb ? -q1 : q1;
      qq = ua / ub;
      p = (na != nb) ? -qq : qq;
      sh = asr64(p, 13);
      w1 = asr64(p9 * sh * sh, 25);
      w2 = asr64(p8 * p, 19);
      r.press = 32'(asr64(p + w1 + w2, 8) + (p7 << 4));
    end

    x  = tf - 32'd76800;
    ha = asr32(({16'b0, s.h} << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
    hb = asr32(asr32(x * h6, 10) * (asr32(x * h3, 11) + 32'd32768), 10) + 32'd2097152;
    hb = asr32(hb * h2 + 32'd8192, 14);
    x  = ha * hb;
    sq = asr32(x, 15);
    x  = x - asr32(asr32(sq * sq, 7) * h1, 4);
    if (x[31]) x = 0;
    if (x > 32'd419430400) x = 32'd419430400;
    r.hum = x[28:12];
    return r;
  endfunction

  always @(posedge clk) cycle <= cycle + 1;

  // input beat taken at the last rising edge
  always @(posedge clk) in_fire <= in_valid && in_ready;

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || in_fire) begin
      if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
        sample_t s;
        s = pending_q.pop_front();
        expected_q.push_back(compensate(s));
        in_valid  <= 1;
        raw_temp  <= s.t;
        raw_press <= s.p;
        raw_hum   <= s.h;
      end else begin
        in_valid <= 0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) out_ready <= 0;
    else if (hold > 0) begin
      out_ready <= 0;
      hold <= hold - 1;
    end else out_ready <= calm || $urandom_range(99) >= 7;
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report("unexpected beat", 0, 0);
      end else begin
        comp_t e;
        e = expected_q.pop_front();
        if (temp_centideg !== e.temp) report("temp_centideg", temp_centideg, e.temp);
        if (press_q24_8 !== e.press) report("press_q24_8", press_q24_8, e.press);
        if (hum_q22_10 !== e.hum) report("hum_q22_10", hum_q22_10, e.hum);
        if (press_div_zero !== e.dz) report("press_div_zero", press_div_zero, e.dz);
      end
    end
  end

  always @(posedge clk) begin
    if (cycle > LIMIT) begin
      $display("env_sensor_compensation: mismatch");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] v);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= ADDR_W'(int'(idx) * 8);
    pwdata <= v;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_CAL_TEMP:  cal[0] = v & 64'hFFFF_FFFF_FFFF;
      REG_CAL_MIXED: cal[3] = v & 64'hFFFF_FFFF_FFFF;
      REG_CAL_HUM_B: cal[4] = v & 64'hFFFF_FFFF;
      REG_CAL_PRESS_A: cal[1] = v;
      default: cal[2] = v;
    endcase
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [63:0] r64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic add(input logic [19:0] t, input logic [19:0] p, input logic [15:0] h);
    pending_q.push_back({t, p, h});
  endtask

  task automatic typical_cal();
    // plausible chip calibration with some jitter
    write_reg(REG_CAL_TEMP, {16'($signed(-1000 + int'($urandom_range(2000)))),
      16'(26000 + $urandom_range(2000)), 16'(27000 + $urandom_range(2000))});
    write_reg(REG_CAL_PRESS_A, {16'(7000 + $urandom_range(2000)), 16'(3000 + $urandom_range(2000)),
      16'(-10700 + int'($urandom_range(100))), 16'(36000 + $urandom_range(3000))});
    write_reg(REG_CAL_PRESS_B, {16'(-12000 + int'($urandom_range(2000))),
      16'(15000 + $urandom_range(1000)), 16'(-7), 16'(140 + $urandom_range(100))});
    write_reg(REG_CAL_MIXED, {8'(0 + $urandom_range(255)), 16'(360 + $urandom_range(40)),
      8'($urandom_range(100)), 16'(6000)});
    write_reg(REG_CAL_HUM_B, {8'(30), 12'(50), 12'(300 + $urandom_range(50))});
  endtask

  initial begin
    int i;
    for (i = 0; i < 5; i++) cal[i] = 0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 0;

    // reset calibration: divisor zero
    add(0, 0, 0);
    add(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    drain();

    typical_cal();
    add(20'h80000, 20'h50000, 16'h6000);
    add(0, 0, 0);
    add(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    add(20'h7E000, 20'h55000, 0);
    add(20'h7E000, 20'h55000, 16'hFFFF);
    add(20'h7E000, 20'h0, 16'h8000);
    add(20'h7E000, 20'hFFFFF, 16'h8000);
    drain();

    write_reg(REG_CAL_TEMP, 64'hFFFF_FFFF_FFFF);
    write_reg(REG_CAL_PRESS_A, '1);
    write_reg(REG_CAL_PRESS_B, '1);
    write_reg(REG_CAL_MIXED, 64'hFFFF_FFFF_FFFF);
    write_reg(REG_CAL_HUM_B, 64'hFFFF_FFFF);
    add(0, 0, 0);
    add(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    add(20'h12345, 20'hABCDE, 16'h5A5A);
    drain();

    write_reg(REG_CAL_TEMP, 64'h8000_8000_0000);
    write_reg(REG_CAL_PRESS_A, 64'h8000_8000_8000_FFFF);
    write_reg(REG_CAL_PRESS_B, 64'h7FFF_7FFF_7FFF_7FFF);
    write_reg(REG_CAL_MIXED, 64'hFF_7FFF_FF_8000);
    write_reg(REG_CAL_HUM_B, 64'h80_800_7FF);
    add(0, 0, 0);
    add(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    add(20'hAAAAA, 20'h55555, 16'hAAAA);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 3) begin
        write_reg(REG_CAL_TEMP, r64());
        write_reg(REG_CAL_PRESS_A, r64());
        write_reg(REG_CAL_PRESS_B, r64());
        write_reg(REG_CAL_MIXED, r64());
        write_reg(REG_CAL_HUM_B, r64());
      end else typical_cal();
      calm = (phase == 1);
      if (phase == 2) hold = 300;
      for (i = 0; i < 95; i++) begin
        if ($urandom_range(9) == 0)
          add(20'($urandom()), 20'($urandom()), 16'($urandom()));
        else
          add(20'(20'h70000 + $urandom_range(20'h20000)), 20'(20'h40000 + $urandom_range(20'h30000)),
              16'(16'h4000 + $urandom_range(16'h6000)));
      end
      drain();
    end

    if (errors == 0) $display("env_sensor_compensation: match");
    else $display("env_sensor_compensation: mismatch");
    $finish;
  end

endmodule
